### hdl/rhsm_pkg.sv
`default_nettype none
// ============================================================================
// rhsm_pkg: shared types and constants of the rolling hash string matcher
// Widths, register indexes and the status bundle of the modulo reducer.
// ============================================================================
package rhsm_pkg;

    // Pattern and window geometry.
    localparam int MAX_PATTERN = 16;
    localparam int IDX_W       = 4;
    localparam int LEN_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int PAT_HALF    = 8;

    // Hash and text index widths.
    localparam int HASH_W = 16;
    localparam int POS_W  = 32;
    localparam int PROD_W = HASH_W + BYTE_W;

    // Modulo reducer: RED_STEPS restoring steps per cycle.
    localparam int RED_STEPS   = 4;
    localparam int RED_STEP_W  = 2;
    localparam int RED_CNT_W   = 3;
    localparam int RED_W       = 32;
    localparam int RED_SHIFT_W = 5;

    // Configuration port.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_LO = 3;

    // Register indexes.
    typedef enum logic [1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_PATTERN_LOW    = 2'd1,
        REG_PATTERN_HIGH   = 2'd2,
        REG_HASH_MODULUS   = 2'd3
    } reg_index_t;

    // Status of the shared reducer.
    typedef struct packed {
        logic busy;
        logic done;
    } red_status_t;

    // Multiply by the hash base 62 as 64x - 2x.
    function automatic logic [RED_W-1:0] mul_base(input logic [RED_W-1:0] x);
        return (x << 6) - (x << 1);
    endfunction

endpackage
`default_nettype wire

### hdl/rhsm_reducer.sv
`default_nettype none
// ============================================================================
// rhsm_reducer: iterative modulo reducer
// Reduces a 32-bit value modulo a 16-bit modulus by restoring subtraction,
// four quotient bits per cycle.
// ============================================================================
module rhsm_reducer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rhsm_pkg::RED_W-1:0]   value,
    input  logic [rhsm_pkg::HASH_W-1:0]  modulus,
    output rhsm_pkg::red_status_t        status,
    output logic [rhsm_pkg::HASH_W-1:0]  result
);
    import rhsm_pkg::*;

    logic [RED_W-1:0]     rem_reg, rem_next;
    logic [RED_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [RED_W-1:0]     mod_ext;
    logic [RED_W-1:0]     stepped;

    assign mod_ext = {{(RED_W-HASH_W){1'b0}}, modulus};

    // Four restoring steps, from the highest quotient bit of this cycle down.
    always_comb
    begin : step_logic
        logic [RED_W-1:0]       r;
        logic [RED_SHIFT_W-1:0] k;
        r = rem_reg;
        for (int s = 0; s < RED_STEPS; s++)
        begin
            k = {cnt_reg, RED_STEP_W'(RED_STEPS - 1 - s)};
            if ((r >> k) >= mod_ext)
            begin
                r = r - (mod_ext << k);
            end
        end
        stepped = r;
    end

    // Job control: a start always reloads, even over a running job.
    always_comb
    begin
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = value;
            cnt_next  = '1;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = stepped;
            cnt_next = cnt_reg - RED_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign result      = rem_reg[HASH_W-1:0];

endmodule
`default_nettype wire

### hdl/rolling_hash_string_matcher.sv
`default_nettype none
// ============================================================================
// rolling_hash_string_matcher: Rabin-Karp matcher over a text byte stream
// Keeps the last 16 text bytes and a base-62 rolling hash modulo a configured
// modulus, and confirms every hash hit byte by byte against the pattern.
// ============================================================================
//
//  Channel  | Direction | Handshake                    | Payload
//  ---------+-----------+------------------------------+--------------------
//  text     | in        | text_valid / text_stall      | text_byte, text_start
//  result   | out       | result_valid / result_stall  | found, match_start
//  config   | in        | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
//  A text item passes ST_MUL, ST_ISSUE, ST_WAIT and ST_CHECK on its way to the
//  result register, waiting in ST_WAIT on the shared modulo reducer; the next
//  item is taken only after that, from ST_IDLE. After reset and after each
//  register write the pattern hash, removal weight and window hash are rebuilt;
//  text_stall stays high meanwhile and during a write. A result waits in the
//  output register; only the next result's write waits.
//
module rolling_hash_string_matcher (
    input  logic                              clk,
    input  logic                              rst_n,
    // Text items.
    input  logic                              text_valid,
    output logic                              text_stall,
    input  logic [rhsm_pkg::BYTE_W-1:0]       text_byte,
    input  logic                              text_start,
    // Result items.
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              found,
    output logic [rhsm_pkg::POS_W-1:0]        match_start,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rhsm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [rhsm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [rhsm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import rhsm_pkg::*;

    typedef enum logic [7:0] {
        ST_DRV_START = 8'b0000_0001,
        ST_DRV_NEXT  = 8'b0000_0010,
        ST_DRV_WAIT  = 8'b0000_0100,
        ST_IDLE      = 8'b0000_1000,
        ST_MUL       = 8'b0001_0000,
        ST_ISSUE     = 8'b0010_0000,
        ST_WAIT      = 8'b0100_0000,
        ST_CHECK     = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        PH_PAT = 3'b001,
        PH_WGT = 3'b010,
        PH_TXT = 3'b100
    } phase_t;

    // Configuration registers.
    logic [LEN_W-1:0]      pat_len_reg;
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [HASH_W-1:0]     modulus_reg;
    logic                  cfg_wr;
    reg_index_t            cfg_idx;

    // Derived settings.
    logic [LEN_W-1:0]  p_eff;
    logic [LEN_W-1:0]  p_m1;
    logic [HASH_W-1:0] q_eff;
    logic [BYTE_W-1:0] pat_bytes [MAX_PATTERN];

    // Matcher state.
    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [HASH_W-1:0] acc_reg, acc_next;
    logic [BYTE_W-1:0] window_reg [MAX_PATTERN];
    logic [BYTE_W-1:0] window_next [MAX_PATTERN];
    logic [HASH_W-1:0] text_hash_reg, text_hash_next;
    logic [HASH_W-1:0] pattern_hash_reg, pattern_hash_next;
    logic [HASH_W-1:0] weight_reg, weight_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    // Item payload in flight.
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              hit_reg, hit_next;
    logic [POS_W-1:0]  mstart_reg, mstart_next;

    // Output register.
    logic              res_valid_reg, res_valid_next;
    logic              found_reg, found_next;
    logic [POS_W-1:0]  mstart_out_reg, mstart_out_next;

    // Reducer interface and helpers.
    logic              red_start;
    logic [RED_W-1:0]  red_value;
    red_status_t       red_status;
    logic [HASH_W-1:0] red_result;
    logic [LEN_W-1:0]  cnt_m1;
    logic [IDX_W-1:0]  rd_idx;
    logic [BYTE_W-1:0] rd_byte;
    logic [LEN_W-1:0]  held;
    logic [POS_W-1:0]  p_m1_ext;
    logic [PROD_W-1:0] corr;
    logic              bytes_ok;

    // Shared modulo unit.
    rhsm_reducer u_reducer (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (red_start),
        .value   (red_value),
        .modulus (q_eff),
        .status  (red_status),
        .result  (red_result)
    );

    // Configuration port decode.
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_index_t'(paddr[CFG_ADDR_W-1:CFG_IDX_LO]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_PATTERN_LENGTH: prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, pat_len_reg};
            REG_PATTERN_LOW:    prdata = pat_low_reg;
            REG_PATTERN_HIGH:   prdata = pat_high_reg;
            REG_HASH_MODULUS:   prdata = {{(CFG_DATA_W-HASH_W){1'b0}}, modulus_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg  <= LEN_W'(1);
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            modulus_reg  <= HASH_W'(101);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_PATTERN_LENGTH: pat_len_reg  <= pwdata[LEN_W-1:0];
                REG_PATTERN_LOW:    pat_low_reg  <= pwdata;
                REG_PATTERN_HIGH:   pat_high_reg <= pwdata;
                REG_HASH_MODULUS:   modulus_reg  <= pwdata[HASH_W-1:0];
                default:            pat_len_reg  <= pat_len_reg;
            endcase
        end
    end

    // Effective pattern length and modulus, with out-of-range values clamped.
    always_comb
    begin
        if (pat_len_reg == '0)
            p_eff = LEN_W'(1);
        else if (pat_len_reg > LEN_W'(MAX_PATTERN))
            p_eff = LEN_W'(MAX_PATTERN);
        else
            p_eff = pat_len_reg;
    end

    assign q_eff    = (modulus_reg < HASH_W'(2)) ? HASH_W'(2) : modulus_reg;
    assign p_m1     = p_eff - LEN_W'(1);
    assign p_m1_ext = {{(POS_W-LEN_W){1'b0}}, p_m1};
    assign held     = (pos_reg < {{(POS_W-LEN_W){1'b0}}, p_eff}) ? pos_reg[LEN_W-1:0]
                                                                   : p_eff;

    // Pattern bytes, byte 0 in the low bits of the low register.
    always_comb
    begin
        for (int j = 0; j < PAT_HALF; j++)
        begin
            pat_bytes[j]            = pat_low_reg[BYTE_W*j +: BYTE_W];
            pat_bytes[j + PAT_HALF] = pat_high_reg[BYTE_W*j +: BYTE_W];
        end
    end

    // Single window read port: oldest byte for an item, or the byte that the
    // window hash rebuild walks over.
    assign cnt_m1  = cnt_reg - LEN_W'(1);
    assign rd_idx  = (state_reg == ST_DRV_NEXT) ? cnt_m1[IDX_W-1:0] : p_m1[IDX_W-1:0];
    assign rd_byte = window_reg[rd_idx];

    // Byte-by-byte confirmation, one comparator per window lane.
    always_comb
    begin : lane_check
        logic [LEN_W-1:0] lane_idx;
        bytes_ok = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            lane_idx = p_m1 - LEN_W'(j);
            if ((LEN_W'(j) < p_eff) && (window_reg[j] != pat_bytes[lane_idx[IDX_W-1:0]]))
            begin
                bytes_ok = 1'b0;
            end
        end
    end

    // Offset that keeps the removal of the oldest byte non-negative.
    assign corr = {q_eff, {BYTE_W{1'b0}}} - prod_reg;

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        cnt_next          = cnt_reg;
        acc_next          = acc_reg;
        window_next       = window_reg;
        text_hash_next    = text_hash_reg;
        pattern_hash_next = pattern_hash_reg;
        weight_next       = weight_reg;
        pos_next          = pos_reg;
        byte_next         = byte_reg;
        prod_next         = prod_reg;
        hit_next          = hit_reg;
        mstart_next       = mstart_reg;
        res_valid_next    = res_valid_reg;
        found_next        = found_reg;
        mstart_out_next   = mstart_out_reg;
        red_start         = 1'b0;
        red_value         = '0;

        // The output register empties when its item is taken.
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            // Rebuild the pattern hash, removal weight and window hash.
            ST_DRV_START:
            begin
                phase_next = PH_PAT;
                cnt_next   = '0;
                acc_next   = '0;
                state_next = ST_DRV_NEXT;
            end

            ST_DRV_NEXT:
            begin
                unique case (phase_reg)
                    PH_PAT:
                    begin
                        if (cnt_reg == p_eff)
                        begin
                            pattern_hash_next = acc_reg;
                            phase_next        = PH_WGT;
                            cnt_next          = LEN_W'(1);
                            acc_next          = HASH_W'(1);
                        end
                        else
                        begin
                            red_start  = 1'b1;
                            red_value  = mul_base({{(RED_W-HASH_W){1'b0}}, acc_reg})
                                       + {{(RED_W-BYTE_W){1'b0}},
                                          pat_bytes[cnt_reg[IDX_W-1:0]]};
                            state_next = ST_DRV_WAIT;
                        end
                    end
                    PH_WGT:
                    begin
                        if (cnt_reg == p_eff)
                        begin
                            weight_next = acc_reg;
                            phase_next  = PH_TXT;
                            cnt_next    = held;
                            acc_next    = '0;
                        end
                        else
                        begin
                            red_start  = 1'b1;
                            red_value  = mul_base({{(RED_W-HASH_W){1'b0}}, acc_reg});
                            state_next = ST_DRV_WAIT;
                        end
                    end
                    PH_TXT:
                    begin
                        if (cnt_reg == '0)
                        begin
                            text_hash_next = acc_reg;
                            state_next     = ST_IDLE;
                        end
                        else
                        begin
                            red_start  = 1'b1;
                            red_value  = mul_base({{(RED_W-HASH_W){1'b0}}, acc_reg})
                                       + {{(RED_W-BYTE_W){1'b0}}, rd_byte};
                            state_next = ST_DRV_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DRV_START;
                    end
                endcase
            end

            ST_DRV_WAIT:
            begin
                if (red_status.done)
                begin
                    acc_next   = red_result;
                    cnt_next   = (phase_reg == PH_TXT) ? cnt_m1 : cnt_reg + LEN_W'(1);
                    state_next = ST_DRV_NEXT;
                end
            end

            // Take a text item; a start byte opens a fresh, empty window.
            ST_IDLE:
            begin
                if (text_valid)
                begin
                    byte_next = text_byte;
                    if (text_start)
                    begin
                        pos_next       = '0;
                        text_hash_next = '0;
                        for (int j = 0; j < MAX_PATTERN; j++)
                        begin
                            window_next[j] = '0;
                        end
                    end
                    state_next = ST_MUL;
                end
            end

            // Weight of the byte that leaves the window.
            ST_MUL:
            begin
                prod_next  = {{(PROD_W-BYTE_W){1'b0}}, rd_byte}
                           * {{(PROD_W-HASH_W){1'b0}}, weight_reg};
                state_next = ST_ISSUE;
            end

            // Roll the hash, shift the window and advance the text index.
            ST_ISSUE:
            begin
                red_start = 1'b1;
                red_value = mul_base({{(RED_W-HASH_W){1'b0}}, text_hash_reg})
                          + {{(RED_W-BYTE_W){1'b0}}, byte_reg};
                if (pos_reg >= {{(POS_W-LEN_W){1'b0}}, p_eff})
                begin
                    red_value = red_value + mul_base({{(RED_W-PROD_W){1'b0}}, corr});
                end
                for (int j = MAX_PATTERN - 1; j > 0; j--)
                begin
                    window_next[j] = window_reg[j-1];
                end
                window_next[0] = byte_reg;
                if (pos_reg != '1)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                hit_next    = (pos_reg >= p_m1_ext);
                mstart_next = pos_reg - p_m1_ext;
                state_next  = ST_WAIT;
            end

            ST_WAIT:
            begin
                if (red_status.done)
                begin
                    text_hash_next = red_result;
                    state_next     = ST_CHECK;
                end
            end

            // Confirm a hash hit and hand the result to the output register.
            ST_CHECK:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next  = 1'b1;
                    found_next      = hit_reg && (text_hash_reg == pattern_hash_reg)
                                    && bytes_ok;
                    mstart_out_next = hit_reg ? mstart_reg : '0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_DRV_START;
            end
        endcase

        // Any register write restarts the rebuild.
        if (cfg_wr)
        begin
            state_next = ST_DRV_START;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_DRV_START;
            phase_reg        <= PH_PAT;
            cnt_reg          <= '0;
            text_hash_reg    <= '0;
            pattern_hash_reg <= '0;
            weight_reg       <= '0;
            pos_reg          <= '0;
            res_valid_reg    <= 1'b0;
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                window_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            cnt_reg          <= cnt_next;
            text_hash_reg    <= text_hash_next;
            pattern_hash_reg <= pattern_hash_next;
            weight_reg       <= weight_next;
            pos_reg          <= pos_next;
            res_valid_reg    <= res_valid_next;
            window_reg       <= window_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        byte_reg       <= byte_next;
        prod_reg       <= prod_next;
        hit_reg        <= hit_next;
        mstart_reg     <= mstart_next;
        found_reg      <= found_next;
        mstart_out_reg <= mstart_out_next;
    end

    // A register write takes the edge, so no text item is taken with it.
    assign text_stall   = (state_reg != ST_IDLE) | cfg_wr;
    assign result_valid = res_valid_reg;
    assign found        = found_reg;
    assign match_start  = mstart_out_reg;

endmodule
`default_nettype wire

### sim/rhsm_match_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// rhsm_match_checker: scoreboard for the rolling hash string matcher
// Follows register writes and accepted text items and keeps a queue of the
// found flag and window start each item should produce. Every accepted result
// is compared field by field with the oldest entry of that queue.
// ============================================================================
module rhsm_match_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            text_valid,
    input  logic                            text_stall,
    input  logic [rhsm_pkg::BYTE_W-1:0]     text_byte,
    input  logic                            text_start,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  logic                            found,
    input  logic [rhsm_pkg::POS_W-1:0]      match_start,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [rhsm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rhsm_pkg::CFG_DATA_W-1:0] pwdata,
    output int unsigned                     fail_count,
    output int unsigned                     results_pending
);
    import rhsm_pkg::*;

    localparam int unsigned HASH_BASE = 62;
    localparam logic [POS_W-1:0] POS_LIMIT = '1;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start;
    } match_result_t;

    // Register copies.
    logic [LEN_W-1:0]      len_reg;
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [HASH_W-1:0]     mod_reg;

    // Matcher state; held_bytes[0] is the newest byte.
    logic [BYTE_W-1:0] held_bytes [MAX_PATTERN];
    int unsigned       window_hash;
    int unsigned       pattern_hash;
    int unsigned       drop_weight;
    logic [POS_W-1:0]  text_index;

    match_result_t expected_matches [$];
    int unsigned   mismatches;

    assign fail_count = mismatches;

    // Pattern length and modulus as the block uses them.
    function automatic int unsigned used_length();
        if (len_reg == 0)
            return 1;
        if (len_reg > MAX_PATTERN)
            return MAX_PATTERN;
        return 32'(len_reg);
    endfunction

    function automatic int unsigned used_modulus();
        return (mod_reg < 2) ? 2 : 32'(mod_reg);
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_byte(input int unsigned j);
        if (j < PAT_HALF)
            return pat_low_reg[BYTE_W*j +: BYTE_W];
        return pat_high_reg[BYTE_W*(j-PAT_HALF) +: BYTE_W];
    endfunction

    // Rebuild the pattern hash, the weight of the byte leaving the window and
    // the hash of the bytes of the current text still held.
    task automatic rebuild_hashes();
        int unsigned p, q, held, h, w, i;
        p = used_length();
        q = used_modulus();
        held = (text_index < p) ? text_index : p;
        h = 0;
        for (i = 0; i < p; i++)
            h = (HASH_BASE * h + pattern_byte(i)) % q;
        pattern_hash = h;
        w = 1 % q;
        for (i = 1; i < p; i++)
            w = (HASH_BASE * w) % q;
        drop_weight = w;
        h = 0;
        for (i = held; i > 0; i--)
            h = (HASH_BASE * h + held_bytes[IDX_W'(i-1)]) % q;
        window_hash = h;
    endtask

    task automatic apply_register_write();
        case (reg_index_t'(paddr[CFG_ADDR_W-1:CFG_IDX_LO]))
            REG_PATTERN_LENGTH: len_reg = pwdata[LEN_W-1:0];
            REG_PATTERN_LOW:    pat_low_reg = pwdata;
            REG_PATTERN_HIGH:   pat_high_reg = pwdata;
            REG_HASH_MODULUS:   mod_reg = pwdata[HASH_W-1:0];
            default:            ;
        endcase
        rebuild_hashes();
    endtask

    // Advance the rolling hash by one text byte and queue the match it gives.
    task automatic predict_match(input logic [BYTE_W-1:0] b, input logic first);
        int unsigned p, q, sub, t, k;
        logic [POS_W-1:0] pos;
        match_result_t want;
        logic hit;
        p = used_length();
        q = used_modulus();
        if (first)
        begin
            text_index = '0;
            window_hash = 0;
            for (k = 0; k < MAX_PATTERN; k++)
                held_bytes[IDX_W'(k)] = '0;
        end
        pos = text_index;
        if (pos >= p)
        begin
            sub = (held_bytes[IDX_W'(p-1)] * drop_weight) % q;
            t = (window_hash + q - sub) % q;
            window_hash = (HASH_BASE * t + b) % q;
        end
        else
            window_hash = (HASH_BASE * window_hash + b) % q;
        for (k = MAX_PATTERN - 1; k > 0; k--)
            held_bytes[IDX_W'(k)] = held_bytes[IDX_W'(k-1)];
        held_bytes[0] = b;
        if (text_index != POS_LIMIT)
            text_index = text_index + 1'b1;

        // Until the window is full the result is all zero.
        want = '0;
        if (pos + 1 >= p || pos == POS_LIMIT)
        begin
            hit = (window_hash == pattern_hash);
            for (k = 0; k < p; k++)
                if (held_bytes[IDX_W'(p-1-k)] != pattern_byte(k))
                    hit = 1'b0;
            want.found = hit;
            want.start = pos - (p - 1);
        end
        expected_matches.push_back(want);
    endtask

    task automatic check_result();
        match_result_t want;
        if (expected_matches.size() == 0)
        begin
            $display("%0t: result with no item pending, expected none, got found %0b start %0d",
                     $time, found, match_start);
            mismatches++;
            return;
        end
        want = expected_matches.pop_front();
        if (found !== want.found)
        begin
            $display("%0t: found mismatch, expected %0b, got %0b", $time, want.found, found);
            mismatches++;
        end
        if (match_start !== want.start)
        begin
            $display("%0t: match_start mismatch, expected %0d, got %0d",
                     $time, want.start, match_start);
            mismatches++;
        end
    endtask

    // Results are checked before this edge's text item is predicted, so a
    // result can never be matched against an item taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg = 5'd1;
            pat_low_reg = '0;
            pat_high_reg = '0;
            mod_reg = 16'd101;
            for (int k = 0; k < MAX_PATTERN; k++)
                held_bytes[IDX_W'(k)] = '0;
            text_index = '0;
            rebuild_hashes();
            expected_matches.delete();
            mismatches = 0;
            results_pending <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result();
            if (psel && penable && pwrite && pready)
                apply_register_write();
            if (text_valid && !text_stall)
                predict_match(text_byte, text_start);
            results_pending <= expected_matches.size();
        end
    end

endmodule

### sim/tb_rolling_hash_string_matcher.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_rolling_hash_string_matcher: testbench of the rolling hash matcher
// Drives text items and register writes, stalls the result side at random
// and leaves prediction and comparison to the checker beside the block.
// A short directed run covers the corner cases, then phases of random
// settings feed text built mostly from whole or damaged copies of the pattern.
// ============================================================================
module tb_rolling_hash_string_matcher;
    import rhsm_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1300;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  text_valid = 1'b0;
    logic                  text_stall;
    logic [BYTE_W-1:0]     text_byte = '0;
    logic                  text_start = 1'b0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic                  found;
    logic [POS_W-1:0]      match_start;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned fail_count;
    int unsigned results_pending;

    // Idle rates of both sides, in percent of cycles.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;

    // Settings the random text is built from.
    logic [LEN_W-1:0]  len_written;
    logic [BYTE_W-1:0] pattern_text [MAX_PATTERN];

    rolling_hash_string_matcher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_byte    (text_byte),
        .text_start   (text_start),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .match_start  (match_start),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    rhsm_match_checker match_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .text_valid      (text_valid),
        .text_stall      (text_stall),
        .text_byte       (text_byte),
        .text_start      (text_start),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .found           (found),
        .match_start     (match_start),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side stalls at the rate of the current phase.
    always @(posedge clk)
        result_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // The pending count is a registered copy of the checker's queue size.
    task automatic wait_results_drained();
        do
            @(posedge clk);
        while (results_pending != 0);
    endtask

    // Register write with a setup and an access cycle, only while idle.
    task automatic write_register(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        wait_results_drained();
        while (text_stall)
            @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= CFG_ADDR_W'(idx) << CFG_IDX_LO;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offer one text item, after a random gap, and hold it until taken.
    task automatic send_text_item(input logic [BYTE_W-1:0] b, input logic first);
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct);
        end
        text_valid <= 1'b1;
        text_byte <= b;
        text_start <= first;
        do
            @(posedge clk);
        while (text_stall);
    endtask

    task automatic stop_text();
        text_valid <= 1'b0;
    endtask

    // Either a byte of the pattern or any byte at all.
    function automatic logic [BYTE_W-1:0] noise_byte();
        if ($urandom_range(1, 0) != 0)
            return pattern_text[IDX_W'($urandom_range(MAX_PATTERN - 1, 0))];
        return BYTE_W'($urandom());
    endfunction

    // Pick new settings for a phase; some registers keep their old value.
    task automatic configure_phase(input bit write_all);
        logic [CFG_DATA_W-1:0] value;
        logic [BYTE_W-1:0] fill;
        logic [HASH_W-1:0] modv;
        int unsigned sel, style, k;
        bit wl, wp, wm;
        wl = write_all || $urandom_range(1, 0);
        wp = write_all || $urandom_range(1, 0);
        wm = write_all || $urandom_range(1, 0);
        if (!(wl || wp || wm))
            wm = 1'b1;

        if (wl)
        begin
            sel = $urandom_range(99, 0);
            if (sel < 70)
                len_written = LEN_W'($urandom_range(6, 1));
            else if (sel < 85)
                len_written = LEN_W'($urandom_range(16, 7));
            else if (sel < 93)
                len_written = LEN_W'($urandom_range(31, 17));
            else
                len_written = '0;
            value = {$urandom(), $urandom()};
            value[LEN_W-1:0] = len_written;
            write_register(REG_PATTERN_LENGTH, value);
        end

        if (wp)
        begin
            // Small alphabet, any bytes, or a pattern of all zeros or all ones.
            style = $urandom_range(9, 0);
            fill = ($urandom_range(1, 0) != 0) ? 8'hFF : 8'h00;
            for (k = 0; k < MAX_PATTERN; k++)
                if (style < 5)
                    pattern_text[k] = 8'h41 + BYTE_W'($urandom_range(3, 0));
                else if (style < 9)
                    pattern_text[k] = BYTE_W'($urandom());
                else
                    pattern_text[k] = fill;
            for (k = 0; k < PAT_HALF; k++)
                value[BYTE_W*k +: BYTE_W] = pattern_text[k];
            write_register(REG_PATTERN_LOW, value);
            for (k = 0; k < PAT_HALF; k++)
                value[BYTE_W*k +: BYTE_W] = pattern_text[k+PAT_HALF];
            write_register(REG_PATTERN_HIGH, value);
        end

        if (wm)
        begin
            // Small moduli make hash hits without a real match common.
            sel = $urandom_range(99, 0);
            if (sel < 25)
                modv = HASH_W'($urandom_range(13, 2));
            else if (sel < 45)
                modv = HASH_W'($urandom_range(300, 14));
            else if (sel < 60)
                modv = 16'hFFFF - HASH_W'($urandom_range(20, 0));
            else if (sel < 70)
                modv = HASH_W'($urandom_range(1, 0));
            else
                modv = HASH_W'($urandom());
            value = {$urandom(), $urandom()};
            value[HASH_W-1:0] = modv;
            write_register(REG_HASH_MODULUS, value);
        end
    endtask

    // Random text: whole copies of the pattern, some with one bit flipped,
    // prefixes that break off, and short runs of noise.
    task automatic run_random_text(input int unsigned count, input bit fresh_text);
        logic [BYTE_W-1:0] plan [$];
        logic [BYTE_W-1:0] b;
        int unsigned p, n, k, cut, kind;
        logic first;
        p = (len_written == 0) ? 1 : ((len_written > MAX_PATTERN) ? MAX_PATTERN : len_written);
        for (n = 0; n < count; n++)
        begin
            if (plan.size() == 0)
            begin
                kind = $urandom_range(9, 0);
                if (kind < 5)
                begin
                    cut = ($urandom_range(3, 0) == 0) ? $urandom_range(p - 1, 0) : p;
                    for (k = 0; k < p; k++)
                    begin
                        b = pattern_text[k];
                        if (k == cut)
                            b = b ^ (8'd1 << $urandom_range(7, 0));
                        plan.push_back(b);
                    end
                end
                else if (kind < 7)
                begin
                    cut = $urandom_range(p - 1, 0);
                    for (k = 0; k < cut; k++)
                        plan.push_back(pattern_text[k]);
                    plan.push_back(noise_byte());
                end
                else
                    repeat ($urandom_range(4, 1))
                        plan.push_back(noise_byte());
            end
            first = (fresh_text && n == 0) || ($urandom_range(99, 0) < 3);
            send_text_item(plan.pop_front(), first);
        end
        stop_text();
    endtask

    initial
    begin
        int unsigned phase, sent, count;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: one-byte pattern 0x00 modulo 101.
        @(posedge clk);
        send_text_item(8'h00, 1'b1);
        send_text_item(8'hFF, 1'b0);
        stop_text();

        // Pattern "ABC" modulo 7: window filling, a match, a damaged copy.
        write_register(REG_PATTERN_LENGTH, 64'd3);
        write_register(REG_PATTERN_LOW, 64'h0000_0000_0043_4241);
        write_register(REG_PATTERN_HIGH, '1);
        write_register(REG_HASH_MODULUS, 64'd7);
        send_text_item(8'h41, 1'b1);
        send_text_item(8'h42, 1'b0);
        send_text_item(8'h43, 1'b0);
        send_text_item(8'h41, 1'b0);
        send_text_item(8'h42, 1'b0);
        send_text_item(8'h44, 1'b0);
        stop_text();

        // Shorten the pattern in the middle of a text; the held bytes are rehashed.
        write_register(REG_PATTERN_LENGTH, 64'd2);
        send_text_item(8'h41, 1'b0);
        send_text_item(8'h42, 1'b0);
        stop_text();

        // Length zero acts as one and modulus one as two.
        write_register(REG_PATTERN_LOW, '1);
        write_register(REG_PATTERN_LENGTH, 64'd0);
        write_register(REG_HASH_MODULUS, 64'd1);
        send_text_item(8'hFF, 1'b0);
        stop_text();

        // Oversized length acts as sixteen, with the largest modulus.
        write_register(REG_PATTERN_LENGTH, 64'd31);
        write_register(REG_HASH_MODULUS, 64'hFFFF);
        send_text_item(8'hFF, 1'b1);
        repeat (MAX_PATTERN - 1)
            send_text_item(8'hFF, 1'b0);
        stop_text();

        // Random phases, cycling through the idling modes.
        phase = 0;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 86;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 86;
                end
                default:
                begin
                    send_idle_pct = 21;
                    stall_pct = 21;
                end
            endcase
            configure_phase(phase == 0);
            count = $urandom_range(60, 20);
            run_random_text(count, (phase == 0) || ($urandom_range(1, 0) != 0));
            sent += count;
            phase++;
        end

        wait_results_drained();
        repeat (40)
            @(posedge clk);
        if (fail_count == 0 && results_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### files.f
hdl/rhsm_pkg.sv
hdl/rhsm_reducer.sv
hdl/rolling_hash_string_matcher.sv
sim/rhsm_match_checker.sv
sim/tb_rolling_hash_string_matcher.sv
